// ----- rtl/hsvc_pkg.sv -----
// Package for the HSV to ARGB converter: stage word types and the
// channel scaling functions shared by the pipeline stages. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsvc_pkg;

  localparam int unsigned HueW    = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned UnitW   = 17;  // Q1.16 inputs, 65536 is 1.0
  localparam int unsigned SecW    = 3;
  localparam int unsigned SvW     = 2 * UnitW;      // s*v product
  localparam int unsigned XW      = SvW + UnitW;    // s*v*k product
  localparam int unsigned MixW    = 52;             // signed Q.48 channel values
  localparam int unsigned ChanW   = 8;
  localparam int unsigned ArgbW   = 32;

  localparam logic [UnitW-1:0] OneQ16  = 17'h10000;
  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  typedef struct packed {
    logic [SecW-1:0]  sector;
    logic [UnitW-1:0] k;
    logic [SvW-1:0]   sv;
    logic [UnitW-1:0] v;
    logic [UnitW-1:0] t;
  } prep_t;

  typedef struct packed {
    logic [SecW-1:0]         sector;
    logic [XW-1:0]           x;
    logic signed [MixW-1:0]  m;
    logic [ChanW-1:0]        full;
    logic [ChanW-1:0]        alpha;
  } mix_t;

  // floor(x*255 / 2^16), clamped to 255.
  function automatic logic [ChanW-1:0] sat_q16(input logic [UnitW-1:0] x);
    logic [UnitW+ChanW-1:0] p;
    logic [ChanW:0]         top;
    p   = {x, 8'b0} - {8'b0, x};
    top = p[UnitW+ChanW-1:16];
    return top[ChanW] ? ChanMax : top[ChanW-1:0];
  endfunction

  // floor(val*255 / 2^48) for a signed Q.48 value, zero at or below zero,
  // clamped to 255. Positive values always fit in 49 bits.
  function automatic logic [ChanW-1:0] chan_q48(input logic signed [MixW-1:0] val);
    logic [48:0]  u;
    logic [56:0]  p;
    logic [ChanW:0] top;
    u   = val[48:0];
    p   = {u, 8'b0} - {8'b0, u};
    top = p[56:48];
    if (val[MixW-1] || (val == '0)) begin
      return '0;
    end
    return top[ChanW] ? ChanMax : top[ChanW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hsvc_prep.sv -----
// First pipeline stage: hue sector and ramp weight, chroma product s*v.
// Depends on hsvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsvc_prep import hsvc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [HueW-1:0]  hue_i,
  input  wire logic [UnitW-1:0] sat_i,
  input  wire logic [UnitW-1:0] val_i,
  input  wire logic [UnitW-1:0] alpha_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output prep_t                 word_o
);

  logic        valid_q;
  prep_t       word_q, word_d;
  logic [18:0] h6;
  logic [FracW-1:0] frac;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    frac   = hue_i[FracW-1:0];
    h6     = {1'b0, frac, 2'b0} + {2'b0, frac, 1'b0};
    word_d.sector = h6[18:16];
    word_d.k      = h6[16] ? (OneQ16 - {1'b0, h6[15:0]}) : {1'b0, h6[15:0]};
    word_d.sv     = sat_i * val_i;
    word_d.v      = val_i;
    word_d.t      = alpha_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

// ----- rtl/hsvc_mix.sv -----
// Second pipeline stage: ramp product x = s*v*k, base level m = v - c,
// and the full-value and alpha bytes. Depends on hsvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsvc_mix import hsvc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire prep_t word_i,
  output logic       valid_o,
  input  wire logic  ready_i,
  output mix_t       word_o
);

  logic valid_q;
  mix_t word_q, word_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    word_d.sector = word_i.sector;
    word_d.x      = word_i.sv * word_i.k;
    // Both terms sit in Q.48; m goes negative when saturation exceeds one.
    word_d.m      = $signed({3'b0, word_i.v, 32'b0}) - $signed({2'b0, word_i.sv, 16'b0});
    word_d.full   = sat_q16(word_i.v);
    word_d.alpha  = sat_q16(word_i.t);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

// ----- rtl/hsvc_pack.sv -----
// Third and fourth pipeline stages: m + x sum and low byte, then the mid
// byte, sector routing and ARGB packing into the output register.
// Depends on hsvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsvc_pack import hsvc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire mix_t              word_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [ArgbW-1:0]       argb_o
);

  localparam logic [SecW-1:0] SecRed     = 3'd0;
  localparam logic [SecW-1:0] SecYellow  = 3'd1;
  localparam logic [SecW-1:0] SecGreen   = 3'd2;
  localparam logic [SecW-1:0] SecCyan    = 3'd3;
  localparam logic [SecW-1:0] SecBlue    = 3'd4;

  logic                   sum_valid_q;
  logic [SecW-1:0]        sector_q;
  logic signed [MixW-1:0] sum_q;
  logic [ChanW-1:0]       low_q, full_q, alpha_q;
  logic                   sum_ready;

  logic                   out_valid_q;
  logic [ArgbW-1:0]       argb_q, argb_d;
  logic [ChanW-1:0]       mid, r, g, b;

  assign ready_o   = !sum_valid_q || sum_ready;
  assign sum_ready = !out_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (ready_o) begin
      sum_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sector_q <= word_i.sector;
      sum_q    <= word_i.m + $signed({1'b0, word_i.x});
      low_q    <= chan_q48(word_i.m);
      full_q   <= word_i.full;
      alpha_q  <= word_i.alpha;
    end
  end

  always_comb begin
    mid = chan_q48(sum_q);
    case (sector_q)
      SecRed:    begin r = full_q; g = mid;    b = low_q;  end
      SecYellow: begin r = mid;    g = full_q; b = low_q;  end
      SecGreen:  begin r = low_q;  g = full_q; b = mid;    end
      SecCyan:   begin r = low_q;  g = mid;    b = full_q; end
      SecBlue:   begin r = mid;    g = low_q;  b = full_q; end
      default:   begin r = full_q; g = low_q;  b = mid;    end
    endcase
    argb_d = {alpha_q, r, g, b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sum_ready) begin
      out_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready && sum_valid_q) begin
      argb_q <= argb_d;
    end
  end

  assign valid_o = out_valid_q;
  assign argb_o  = argb_q;

endmodule

`default_nettype wire

// ----- rtl/hsv_to_argb_converter_unit.sv -----
// HSV to ARGB converter, top level. Chains the prep, mix and pack stages.
// Depends on hsvc_pkg, hsvc_prep, hsvc_mix and hsvc_pack.
//
// Usage:
//   Input channel: in_valid_i with hue, saturation, brightness and alpha;
//   a word is taken at a clock edge where in_valid_i is high and
//   in_stall_o is low. Output channel: out_valid_o with argb_word_o;
//   the receiver holds out_stall_i high to keep the word in place.
//   Throughput is one word per cycle while out_stall_i is low; each stage
//   register can accept a new word in the same cycle its old one moves on.
//   From acceptance to out_valid_o a word passes the four register stages:
//   sector and s*v multiply, s*v*k multiply, m + x add, then channel
//   scaling and packing.
//   While out_stall_i is high the pipeline keeps filling until every stage
//   holds a word, then in_stall_o rises; nothing is dropped or repeated.
//   Reset (rst_ni low, asynchronous) empties all stages; there is no
//   configuration and no other state.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_argb_converter_unit import hsvc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [HueW-1:0]  hue_turns_i,
  input  wire logic [UnitW-1:0] saturation_i,
  input  wire logic [UnitW-1:0] brightness_i,
  input  wire logic [UnitW-1:0] alpha_level_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ArgbW-1:0]      argb_word_o
);

  logic  prep_ready, prep_valid, mix_ready, mix_valid, pack_ready;
  prep_t prep_word;
  mix_t  mix_word;

  assign in_stall_o = !prep_ready;

  hsvc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (prep_ready),
    .hue_i   (hue_turns_i),
    .sat_i   (saturation_i),
    .val_i   (brightness_i),
    .alpha_i (alpha_level_i),
    .valid_o (prep_valid),
    .ready_i (mix_ready),
    .word_o  (prep_word)
  );

  hsvc_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (mix_ready),
    .word_i  (prep_word),
    .valid_o (mix_valid),
    .ready_i (pack_ready),
    .word_o  (mix_word)
  );

  hsvc_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mix_valid),
    .ready_o (pack_ready),
    .word_i  (mix_word),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .argb_o  (argb_word_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/hsv_to_argb_converter_unit_tb.sv -----
// Testbench for hsv_to_argb_converter_unit: a table of directed words, then random
// words under random idling and back-pressure, each checked against a local color predictor.
// Depends on hsvc_pkg and the converter RTL.
`timescale 1ns / 1ps

module hsv_to_argb_converter_unit_tb;
  import hsvc_pkg::*;

  localparam int unsigned RandWords  = 450;
  localparam int unsigned CycleLimit = 50000;
  localparam int unsigned HoldCycles = 40;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned IdlePct    = 17;

  // Hue sectors, in the order the hue fraction walks through them.
  typedef enum logic [SecW-1:0] {
    SecRedYellow    = 3'd0,
    SecYellowGreen  = 3'd1,
    SecGreenCyan    = 3'd2,
    SecCyanBlue     = 3'd3,
    SecBlueMagenta  = 3'd4,
    SecMagentaRed   = 3'd5
  } hue_sector_e;

  typedef struct {
    logic [HueW-1:0]  hue;
    logic [UnitW-1:0] sat;
    logic [UnitW-1:0] bri;
    logic [UnitW-1:0] alp;
    bit               known;
    logic [ArgbW-1:0] argb;
  } color_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [HueW-1:0]  hue_turns_i;
  logic [UnitW-1:0] saturation_i;
  logic [UnitW-1:0] brightness_i;
  logic [UnitW-1:0] alpha_level_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [ArgbW-1:0] argb_word_o;

  logic [ArgbW-1:0] pending_argb [$];
  logic [ArgbW-1:0] want_argb;
  int unsigned      fail_cnt;
  int unsigned      cycle_cnt;
  bit               quiet;
  bit               hold_req;

  hsv_to_argb_converter_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .hue_turns_i   (hue_turns_i),
    .saturation_i  (saturation_i),
    .brightness_i  (brightness_i),
    .alpha_level_i (alpha_level_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .argb_word_o   (argb_word_o)
  );

  // Directed words. Rows with known set carry a color that follows directly
  // from the inputs; the others are left to the predictor.
  color_row_t dir_rows [22] = '{
    '{32'h0000_0000, 17'h00000, 17'h00000, 17'h00000, 1'b1, 32'h0000_0000},
    '{32'h0000_0000, 17'h00000, 17'h10000, 17'h10000, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0000, 17'h10000, 17'h10000, 17'h10000, 1'b1, 32'hFFFF_0000},
    '{32'h0001_0000, 17'h10000, 17'h10000, 17'h10000, 1'b1, 32'hFFFF_0000},
    '{32'hFFFF_0000, 17'h10000, 17'h10000, 17'h10000, 1'b1, 32'hFFFF_0000},
    '{32'h8000_0000, 17'h10000, 17'h10000, 17'h10000, 1'b1, 32'hFFFF_0000},
    '{32'h0000_8000, 17'h10000, 17'h10000, 17'h10000, 1'b1, 32'hFF00_FFFF},
    '{32'h0000_0000, 17'h00000, 17'h00000, 17'h08000, 1'b1, 32'h7F00_0000},
    '{32'h0000_0000, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1'b1, 32'hFFFF_0000},
    '{32'h0000_0000, 17'h1FFFF, 17'h10000, 17'h00000, 1'b1, 32'h00FF_0000},
    '{32'h0000_0000, 17'h00000, 17'h1FFFF, 17'h1FFFF, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_8000, 17'h18000, 17'h10000, 17'h10000, 1'b1, 32'hFF00_FFFF},
    '{32'h7FFF_FFFF, 17'h10000, 17'h10000, 17'h10000, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 17'h10000, 17'h10000, 17'h10000, 1'b0, 32'h0},
    '{32'h0000_1555, 17'h0C000, 17'h0E000, 17'h04000, 1'b0, 32'h0},
    '{32'h0000_3FFF, 17'h0C000, 17'h0E000, 17'h04000, 1'b0, 32'h0},
    '{32'h0000_6AA9, 17'h0C000, 17'h0E000, 17'h04000, 1'b0, 32'h0},
    '{32'h0000_9553, 17'h0C000, 17'h0E000, 17'h04000, 1'b0, 32'h0},
    '{32'h0000_BFFD, 17'h0C000, 17'h0E000, 17'h04000, 1'b0, 32'h0},
    '{32'h1234_EAA7, 17'h0C000, 17'h0E000, 17'h04000, 1'b0, 32'h0},
    '{32'h0000_2AAB, 17'h10000, 17'h08000, 17'h00001, 1'b0, 32'h0},
    '{32'hFFFF_2AAA, 17'h15555, 17'h0FFFF, 17'h0FFFF, 1'b0, 32'h0}
  };

  // Scales a signed Q.48 channel level to a byte: zero at or below zero,
  // truncated, and saturated at full scale.
  function automatic logic [ChanW-1:0] level_to_byte(input longint signed level);
    logic [63:0] scaled;
    if (level <= 0) begin
      return '0;
    end
    scaled = (64'(level) * 64'd255) >> 48;
    return (scaled > 64'd255) ? 8'hFF : scaled[7:0];
  endfunction

  function automatic logic [ArgbW-1:0] predict_argb(input logic [HueW-1:0] hue,
                                                    input logic [UnitW-1:0] sat,
                                                    input logic [UnitW-1:0] bri,
                                                    input logic [UnitW-1:0] alp);
    logic [18:0]       hue6;
    hue_sector_e       sector;
    logic [15:0]       ramp;
    logic [UnitW-1:0]  weight;
    longint signed     sv, lvl_v, lvl_c, lvl_x, lvl_m;
    logic [ChanW-1:0]  full, mid, low, red, grn, blu, alpha;
    logic [31:0]       alpha_sc;
    hue6   = 19'(hue[15:0]) * 19'd6;
    sector = hue_sector_e'(hue6[18:16]);
    ramp   = hue6[15:0];
    // Odd sectors run the ramp downward.
    weight = sector[0] ? (OneQ16 - 17'(ramp)) : 17'(ramp);
    sv     = longint'(sat) * longint'(bri);
    lvl_v  = longint'(bri) <<< 32;
    lvl_c  = sv <<< 16;
    lvl_x  = sv * longint'(weight);
    lvl_m  = lvl_v - lvl_c;
    full   = level_to_byte(lvl_v);
    mid    = level_to_byte(lvl_m + lvl_x);
    low    = level_to_byte(lvl_m);
    alpha_sc = (32'(alp) * 32'd255) >> 16;
    alpha  = (alpha_sc > 32'd255) ? 8'hFF : alpha_sc[7:0];
    case (sector)
      SecRedYellow: begin
        red = full; grn = mid;  blu = low;
      end
      SecYellowGreen: begin
        red = mid;  grn = full; blu = low;
      end
      SecGreenCyan: begin
        red = low;  grn = full; blu = mid;
      end
      SecCyanBlue: begin
        red = low;  grn = mid;  blu = full;
      end
      SecBlueMagenta: begin
        red = mid;  grn = low;  blu = full;
      end
      default: begin
        red = full; grn = low;  blu = mid;
      end
    endcase
    return {alpha, red, grn, blu};
  endfunction

  // Mostly in range, with the ends and some values above one mixed in.
  function automatic logic [UnitW-1:0] rand_unit();
    int unsigned pick;
    pick = $urandom_range(15);
    case (pick)
      0: begin
        return '0;
      end
      1: begin
        return OneQ16;
      end
      2: begin
        return 17'($urandom_range(131071, 65537));
      end
      default: begin
        return 17'($urandom_range(65536, 0));
      end
    endcase
  endfunction

  function automatic logic [HueW-1:0] rand_hue();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) begin
      return {16'($urandom), 16'h0000};
    end
    return 32'($urandom);
  endfunction

  // Offers one word, idling first at random, and records its color once the
  // handshake completes. Called and returns at a falling edge.
  task automatic offer_word(input color_row_t row);
    int unsigned gap;
    if (!quiet && ($urandom_range(99) < IdlePct)) begin
      gap = $urandom_range(4, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    hue_turns_i   <= row.hue;
    saturation_i  <= row.sat;
    brightness_i  <= row.bri;
    alpha_level_i <= row.alp;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    pending_argb.push_back(row.known ? row.argb
                                     : predict_argb(row.hue, row.sat, row.bri, row.alp));
    @(negedge clk_i);
  endtask

  task automatic drain_pending();
    in_valid_i <= 1'b0;
    while (pending_argb.size() != 0) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  always #1 clk_i = ~clk_i;

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("hsv_to_argb_converter_unit_tb NOT OK");
    $finish;
  end

  // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= !quiet && ($urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_argb.size() == 0) begin
        $display("%0t: unexpected word 0x%08h with nothing pending", $time, argb_word_o);
        fail_cnt++;
      end else begin
        want_argb = pending_argb.pop_front();
        if (argb_word_o !== want_argb) begin
          $display("%0t: argb_word mismatch: expected 0x%08h, actual 0x%08h",
                   $time, want_argb, argb_word_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    color_row_t row;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    hue_turns_i   = '0;
    saturation_i  = '0;
    brightness_i  = '0;
    alpha_level_i = '0;
    fail_cnt      = 0;
    cycle_cnt     = 0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      offer_word(dir_rows[i]);
    end
    // Sender pauses until the pipeline has emptied.
    drain_pending();

    for (int unsigned n = 0; n < RandWords; n++) begin
      quiet = (n >= 100) && (n < 200);
      if (n == 250) begin
        // The receiver holds off while words keep coming, so every stage fills.
        hold_req = 1'b1;
      end
      if (n == 350) begin
        drain_pending();
      end
      row.hue   = rand_hue();
      row.sat   = rand_unit();
      row.bri   = rand_unit();
      row.alp   = rand_unit();
      row.known = 1'b0;
      row.argb  = '0;
      offer_word(row);
    end

    drain_pending();
    repeat (DrainWait) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("hsv_to_argb_converter_unit_tb OK");
    end else begin
      $display("hsv_to_argb_converter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hsvc_pkg.sv
rtl/hsvc_prep.sv
rtl/hsvc_mix.sv
rtl/hsvc_pack.sv
rtl/hsv_to_argb_converter_unit.sv
tb/sv/hsv_to_argb_converter_unit_tb.sv
